// ----- src/pt64_pkg.sv -----
// ----------------------------------------------------------------------------
// pt64_pkg
// Types and constants shared by the primality test controller and datapath.
// ----------------------------------------------------------------------------
package pt64_pkg;

    localparam int NUM_W      = 63;
    localparam int TABLE_SIZE = 12;
    localparam int BIDX_W     = 4;
    localparam int SCNT_W     = 6;

    typedef logic [NUM_W-1:0] num_t;

    function automatic logic [5:0] base_value(input logic [BIDX_W-1:0] idx);
        logic [5:0] v;
        case (idx)
            4'd0:    v = 6'd2;
            4'd1:    v = 6'd3;
            4'd2:    v = 6'd5;
            4'd3:    v = 6'd7;
            4'd4:    v = 6'd11;
            4'd5:    v = 6'd13;
            4'd6:    v = 6'd17;
            4'd7:    v = 6'd19;
            4'd8:    v = 6'd23;
            4'd9:    v = 6'd29;
            4'd10:   v = 6'd31;
            default: v = 6'd37;
        endcase
        return v;
    endfunction

    typedef enum logic [2:0] {
        MUL_ACC_B = 3'b001,
        MUL_B_B   = 3'b010,
        MUL_X_X   = 3'b100
    } mul_sel_t;

    typedef struct packed {
        logic     load_n;
        logic     load_base;
        logic     shift_d;
        logic     init_pow;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     shift_e;
        logic     acc_to_x;
    } dp_cmd_t;

    typedef struct packed {
        logic n_small;
        logic d_odd;
        logic base_ge_n;
        logic base_is_nm1;
        logic e_zero;
        logic e_lsb;
        logic mul_done;
        logic x_is_one;
        logic x_is_nm1;
    } dp_sts_t;

endpackage

// ----- src/pt64_if.sv -----
// ----------------------------------------------------------------------------
// pt64_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface pt64_if #(
    parameter int WIDTH = 1
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/pt64_datapath.sv -----
// ----------------------------------------------------------------------------
// pt64_datapath
// Operand registers and a bit-serial shift-and-add modular multiplier.
// ----------------------------------------------------------------------------
module pt64_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  pt64_pkg::num_t    number,
    input  logic [3:0]        base_idx,
    input  pt64_pkg::dp_cmd_t cmd,
    output pt64_pkg::dp_sts_t sts
);
    logic [63:0] n_reg, d_reg, e_reg, b_reg, acc_reg, x_reg;
    logic [63:0] ma_reg, my_reg, mr_reg;
    logic        mbusy_reg;
    logic        mdst_reg;
    logic [63:0] nm1, base64, ma_in, my_in;
    logic [63:0] sum, sum_red, dbl, dbl_red;

    assign nm1    = n_reg - 64'd1;
    assign base64 = {58'd0, pt64_pkg::base_value(base_idx)};

    always_comb
    begin
        ma_in = acc_reg;
        my_in = b_reg;
        unique case (cmd.mul_sel)
            pt64_pkg::MUL_ACC_B: begin ma_in = acc_reg; my_in = b_reg; end
            pt64_pkg::MUL_B_B:   begin ma_in = b_reg;   my_in = b_reg; end
            pt64_pkg::MUL_X_X:   begin ma_in = x_reg;   my_in = x_reg; end
            default:             begin ma_in = acc_reg; my_in = b_reg; end
        endcase
    end

    assign sum     = mr_reg + ma_reg;
    assign sum_red = (sum >= n_reg) ? sum - n_reg : sum;
    assign dbl     = {ma_reg[62:0], 1'b0};
    assign dbl_red = (dbl >= n_reg) ? dbl - n_reg : dbl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
        end
        else if (cmd.mul_start)
        begin
            mbusy_reg <= 1'b1;
        end
        else if (mbusy_reg && my_reg == 64'd0)
        begin
            mbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_n)
        begin
            n_reg <= {1'b0, number};
            d_reg <= {1'b0, number} - 64'd1;
        end
        if (cmd.shift_d)
        begin
            d_reg <= {1'b0, d_reg[63:1]};
        end
        if (cmd.load_base)
        begin
            b_reg <= base64;
        end
        if (cmd.init_pow)
        begin
            e_reg   <= d_reg;
            acc_reg <= 64'd1;
        end
        if (cmd.shift_e)
        begin
            e_reg <= {1'b0, e_reg[63:1]};
        end
        if (cmd.acc_to_x)
        begin
            x_reg <= acc_reg;
        end
        if (mbusy_reg && my_reg == 64'd0)
        begin
            if (cmd.mul_sel == pt64_pkg::MUL_X_X)
                x_reg <= mr_reg;
            else if (mdst_reg)
                acc_reg <= mr_reg;
            else
                b_reg <= mr_reg;
        end
        if (cmd.mul_start)
        begin
            ma_reg   <= ma_in;
            my_reg   <= my_in;
            mr_reg   <= 64'd0;
            mdst_reg <= (cmd.mul_sel == pt64_pkg::MUL_ACC_B);
        end
        else if (mbusy_reg && my_reg != 64'd0)
        begin
            if (my_reg[0])
                mr_reg <= sum_red;
            ma_reg <= dbl_red;
            my_reg <= {1'b0, my_reg[63:1]};
        end
    end

    assign sts.n_small     = (n_reg < 64'd2);
    assign sts.d_odd       = d_reg[0];
    assign sts.base_ge_n   = (base64 >= n_reg);
    assign sts.base_is_nm1 = (base64 == nm1);
    assign sts.e_zero      = (e_reg == 64'd0);
    assign sts.e_lsb       = e_reg[0];
    assign sts.mul_done    = mbusy_reg && (my_reg == 64'd0);
    assign sts.x_is_one    = (x_reg == 64'd1);
    assign sts.x_is_nm1    = (x_reg == nm1);
endmodule

// ----- src/pt64_ctrl.sv -----
// ----------------------------------------------------------------------------
// pt64_ctrl
// Sequencer for the bases, the exponentiation and the squaring rounds.
// ----------------------------------------------------------------------------
module pt64_ctrl #(
    parameter int NUM_BASES = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              result,
    output logic [3:0]        base_idx,
    output pt64_pkg::dp_cmd_t cmd,
    input  pt64_pkg::dp_sts_t sts
);
    localparam int LAST_BASE = ((NUM_BASES < pt64_pkg::TABLE_SIZE) ? NUM_BASES
                                : pt64_pkg::TABLE_SIZE) - 1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SPLIT  = 11'b00000000010,
        S_BASE   = 11'b00000000100,
        S_PSTEP  = 11'b00000001000,
        S_PMUL   = 11'b00000010000,
        S_PSQ    = 11'b00000100000,
        S_CHECK  = 11'b00001000000,
        S_SQ     = 11'b00010000000,
        S_SQCHK  = 11'b00100000000,
        S_NEXT   = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [3:0]                  bidx_reg, bidx_next;
    logic [pt64_pkg::SCNT_W-1:0] s_reg, s_next, k_reg, k_next;
    logic                        res_reg, res_next;
    logic                        sq_done_reg, sq_done_next;

    assign base_idx  = bidx_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign result    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bidx_reg    <= '0;
            s_reg       <= '0;
            k_reg       <= '0;
            res_reg     <= 1'b0;
            sq_done_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bidx_reg    <= bidx_next;
            s_reg       <= s_next;
            k_reg       <= k_next;
            res_reg     <= res_next;
            sq_done_reg <= sq_done_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bidx_next    = bidx_reg;
        s_next       = s_reg;
        k_next       = k_reg;
        res_next     = res_reg;
        sq_done_next = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = pt64_pkg::MUL_ACC_B;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_n = 1'b1;
                    bidx_next  = '0;
                    s_next     = '0;
                    res_next   = 1'b1;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if (sts.n_small)
                begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end
                else if (!sts.d_odd && s_reg < 6'd63)
                begin
                    cmd.shift_d = 1'b1;
                    s_next      = s_reg + 6'd1;
                end
                else
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                if (sts.base_ge_n)
                    state_next = S_DONE;
                else if (sts.base_is_nm1)
                    state_next = S_NEXT;
                else
                begin
                    cmd.load_base = 1'b1;
                    cmd.init_pow  = 1'b1;
                    state_next    = S_PSTEP;
                end
            end
            S_PSTEP:
            begin
                if (sts.e_zero)
                begin
                    cmd.acc_to_x = 1'b1;
                    state_next   = S_CHECK;
                end
                else if (sts.e_lsb)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_PMUL;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = pt64_pkg::MUL_B_B;
                    state_next    = S_PSQ;
                end
            end
            S_PMUL:
            begin
                if (sts.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = pt64_pkg::MUL_B_B;
                    state_next    = S_PSQ;
                end
            end
            S_PSQ:
            begin
                cmd.mul_sel = pt64_pkg::MUL_B_B;
                if (sts.mul_done)
                begin
                    cmd.shift_e = 1'b1;
                    state_next  = S_PSTEP;
                end
            end
            S_CHECK:
            begin
                if (sts.x_is_one || sts.x_is_nm1)
                    state_next = S_NEXT;
                else
                begin
                    k_next     = 6'd1;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (k_reg >= s_reg)
                begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = pt64_pkg::MUL_X_X;
                    state_next    = S_SQCHK;
                end
            end
            S_SQCHK:
            begin
                cmd.mul_sel = pt64_pkg::MUL_X_X;
                if (sq_done_reg)
                begin
                    if (sts.x_is_one)
                    begin
                        res_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (sts.x_is_nm1)
                        state_next = S_NEXT;
                    else
                    begin
                        k_next     = k_reg + 6'd1;
                        state_next = S_SQ;
                    end
                end
                else if (sts.mul_done)
                begin
                    sq_done_next = 1'b1;
                end
            end
            S_NEXT:
            begin
                if (bidx_reg == 4'(LAST_BASE))
                    state_next = S_DONE;
                else
                begin
                    bidx_next  = bidx_reg + 4'd1;
                    state_next = S_BASE;
                end
            end
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ----- src/primality_test_64.sv -----
// ----------------------------------------------------------------------------
// primality_test_64
// Deterministic Miller-Rabin primality test for integers below 2^63.
// ----------------------------------------------------------------------------
// Usage: present a number on the in channel; one transaction carries one
// number. The block then tests it against up to NUM_BASES small prime bases
// and offers a single is_prime bit on the out channel.
// One number is in flight at a time: in.ready is high only while idle.
// Latency depends on the number: each modular multiply is done bit-serially
// by the shift-and-add multiplier, and a base can need up to about 125
// multiplies, so a full twelve-base run of a 63-bit prime is the longest
// case; small or even numbers finish far sooner.
// The result is held on the out channel until out.ready is seen; no new
// number is taken before that transaction completes.
// Reset returns the sequencer to idle and drops any pending result.
// ----------------------------------------------------------------------------
module primality_test_64 #(
    parameter int NUM_BASES = 12
) (
    input  logic clk,
    input  logic rst_n,
    pt64_if.sink   in_ch,
    pt64_if.source out_ch
);
    pt64_pkg::dp_cmd_t cmd;
    pt64_pkg::dp_sts_t sts;
    logic [3:0]        base_idx;

    pt64_ctrl #(.NUM_BASES(NUM_BASES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .result    (out_ch.data[0]),
        .base_idx  (base_idx),
        .cmd       (cmd),
        .sts       (sts)
    );

    pt64_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .number   (in_ch.data),
        .base_idx (base_idx),
        .cmd      (cmd),
        .sts      (sts)
    );
endmodule

// ----- test/pt64_checker.sv -----
// ----------------------------------------------------------------------------
// pt64_checker
// Watches both channels of the primality tester and checks every verdict.
// Each number accepted on the in channel is run through a local
// Miller-Rabin computation with the same base table. The expected verdict
// is queued and then compared with the next transaction on the out channel.
// ----------------------------------------------------------------------------
module pt64_checker #(
    parameter int NUM_BASES = 12
) (
    input  logic clk,
    input  logic rst_n,
    pt64_if      in_ch,
    pt64_if      out_ch,
    output int   fail_count,
    output int   verdicts_pending
);

    localparam logic [63:0] PRIME_BASES [pt64_pkg::TABLE_SIZE] =
        '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
          64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37};

    logic verdict_q[$];

    function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y,
                                            logic [63:0] m);
        logic [63:0] acc;
        acc = 0;
        while (y != 0)
        begin
            if (y[0])
            begin
                acc = acc + x;
                if (acc >= m)
                    acc = acc - m;
            end
            x = x + x;
            if (x >= m)
                x = x - m;
            y = y >> 1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] mod_pow(logic [63:0] b, logic [63:0] e,
                                            logic [63:0] m);
        logic [63:0] acc;
        acc = 1 % m;
        while (e != 0)
        begin
            if (e[0])
                acc = mod_mul(acc, b, m);
            b = mod_mul(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic proves_composite(logic [63:0] n, logic [63:0] a);
        logic [63:0] nm1;
        logic [63:0] d;
        logic [63:0] x;
        int          s;
        nm1 = n - 1;
        d   = nm1;
        s   = 0;
        if (a < 2 || a == nm1)
            return 1'b0;
        while (!d[0] && s < 63)
        begin
            d = d >> 1;
            s++;
        end
        x = mod_pow(a, d, n);
        if (x == 1 || x == nm1)
            return 1'b0;
        for (int k = 1; k < s; k++)
        begin
            x = mod_mul(x, x, n);
            if (x == 1)
                return 1'b1;
            if (x == nm1)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic primality_verdict(pt64_pkg::num_t number);
        logic [63:0] n;
        n = {1'b0, number};
        if (n < 2)
            return 1'b0;
        for (int i = 0; i < NUM_BASES && i < pt64_pkg::TABLE_SIZE; i++)
        begin
            if (PRIME_BASES[i] >= n)
                break;
            if (proves_composite(n, PRIME_BASES[i]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    assign verdicts_pending = verdict_q.size();

    initial
    begin
        fail_count = 0;
    end

    always @(posedge clk)
    begin
        logic expected;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                verdict_q = {verdict_q, primality_verdict(in_ch.data)};
            if (out_ch.valid && out_ch.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction, is_prime=%0b",
                             $time, out_ch.data[0]);
                    fail_count++;
                end
                else
                begin
                    expected = verdict_q.pop_front();
                    if (out_ch.data[0] !== expected)
                    begin
                        $display("%0t: is_prime mismatch, expected %0b, actual %0b",
                                 $time, expected, out_ch.data[0]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- test/primality_test_64_tb.sv -----
// ----------------------------------------------------------------------------
// primality_test_64_tb
// Stimulus and verdict for the 64-bit primality tester.
// Directed numbers cover zero, one, two, three, the top of the range,
// large primes and strong pseudoprimes; random numbers follow, mostly
// small to keep the run short. Both channels idle at random.
// ----------------------------------------------------------------------------
module primality_test_64_tb;

    localparam longint CYCLE_LIMIT = 40_000_000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   verdicts_pending;
    int   results_seen;

    pt64_if #(.WIDTH(pt64_pkg::NUM_W)) in_ch ();
    pt64_if #(.WIDTH(1))               out_ch ();

    primality_test_64 uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    pt64_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_ch            (in_ch),
        .out_ch           (out_ch),
        .fail_count       (fail_count),
        .verdicts_pending (verdicts_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    function automatic int idle_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 200);
        return $urandom_range(1, 4);
    endfunction

    function automatic pt64_pkg::num_t random_number();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1:    return r[pt64_pkg::NUM_W-1:0];
            2:       return pt64_pkg::num_t'(r[31:0]) | pt64_pkg::num_t'(1);
            3:       return pt64_pkg::num_t'(r[19:0]);
            default: return pt64_pkg::num_t'(r[9:0]);
        endcase
    endfunction

    task automatic send_number(pt64_pkg::num_t number);
        int gap;
        in_ch.data  = number;
        in_ch.valid = 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        gap = idle_gap();
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        pt64_pkg::num_t directed [$];
        directed = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd9, 63'd37,
                     63'd41, 63'd561, 63'd2047, 63'd1373653,
                     63'd25326001, 63'd3215031751, 63'd2152302898747,
                     63'h7FFF_FFFF_FFFF_FFFF, 63'h4000_0000_0000_0000,
                     63'h1FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFE7,
                     63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAB,
                     63'd3825123056546413051};
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[i])
            send_number(directed[i]);
        for (int i = 0; i < 80; i++)
            send_number(random_number());
        in_ch.valid = 1'b0;
        wait (verdicts_pending == 0);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // receiver: random back-pressure plus one long hold-off
    initial
    begin
        int  gap;
        logic held;
        out_ch.ready = 1'b0;
        results_seen = 0;
        held         = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && results_seen == 10)
            begin
                held         = 1'b1;
                out_ch.ready = 1'b0;
                repeat (3000) @(negedge clk);
            end
            gap = idle_gap();
            if (gap > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                out_ch.ready = 1'b1;
                @(posedge clk);
                if (out_ch.valid)
                    results_seen++;
            end
        end
    end

    initial
    begin
        longint cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
